// File: rtl/core/orlk_pkg.sv
// ----------------------------------------------------------------------------
// orlk_pkg
// Types and constants shared by the overwriting ring with offset lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package orlk_pkg;

  localparam int unsigned HandleW = 16;
  localparam int unsigned LengthW = 16;
  localparam int unsigned OffsetW = 20;
  localparam int unsigned PosW    = 8;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 96;

  localparam logic [OffsetW-1:0] OffsetMax = '1;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_FIND   = 2'd1,
    OP_POS    = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [HandleW-1:0] offset_in_entry;
    logic [PosW-1:0]    entry_position;
    logic [OffsetW-1:0] stream_offset;
    logic [LengthW-1:0] new_length;
    logic [HandleW-1:0] new_handle;
    op_e                operation;
  } item_t;

  typedef struct packed {
    logic [OffsetW-1:0] total_length;
    logic [HandleW-1:0] evicted_handle;
    logic               evicted_valid;
    logic               position_error;
    logic [OffsetW-1:0] absolute_offset;
    logic [LengthW-1:0] byte_in_entry;
    logic [HandleW-1:0] slot_handle;
    logic [SlotW-1:0]   slot_index;
    logic               found;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/orlk_store.sv
// ----------------------------------------------------------------------------
// orlk_store
// Ring entry memory: handle and length per slot, one write and one
// registered read per cycle. Never written slots read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module orlk_store #(
  parameter int unsigned RING_DEPTH = 16,
  parameter int unsigned IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            wr_en_i,
  input  wire logic [IW-1:0]                   wr_addr_i,
  input  wire logic [orlk_pkg::HandleW-1:0]    wr_handle_i,
  input  wire logic [orlk_pkg::LengthW-1:0]    wr_length_i,
  input  wire logic [IW-1:0]                   rd_addr_i,
  output logic      [orlk_pkg::HandleW-1:0]    rd_handle_o,
  output logic      [orlk_pkg::LengthW-1:0]    rd_length_o
);
  import orlk_pkg::*;

  logic [HandleW+LengthW-1:0] mem [RING_DEPTH];
  logic [HandleW+LengthW-1:0] rd_data_q;
  logic [RING_DEPTH-1:0]      vld_q;
  logic                       rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_handle_i, wr_length_i};
    end
    rd_data_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_handle_o = rd_vld_q ? rd_data_q[HandleW+LengthW-1:LengthW] : '0;
  assign rd_length_o = rd_vld_q ? rd_data_q[LengthW-1:0] : '0;

endmodule

`default_nettype wire

// File: rtl/core/orlk_ctrl.sv
// ----------------------------------------------------------------------------
// orlk_ctrl
// Sequencer with ring pointers, running total and one shared add/compare
// unit that walks stored lengths one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module orlk_ctrl #(
  parameter int unsigned RING_DEPTH = 16,
  parameter int unsigned IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire orlk_pkg::item_t                 item_i,
  output logic                                 ready_o,
  output logic                                 res_valid_o,
  input  wire logic                            res_ack_i,
  output orlk_pkg::result_t                    res_o,
  output logic                                 wr_en_o,
  output logic      [IW-1:0]                   wr_addr_o,
  output logic      [orlk_pkg::HandleW-1:0]    wr_handle_o,
  output logic      [orlk_pkg::LengthW-1:0]    wr_length_o,
  output logic      [IW-1:0]                   rd_addr_o,
  input  wire logic [orlk_pkg::HandleW-1:0]    rd_handle_i,
  input  wire logic [orlk_pkg::LengthW-1:0]    rd_length_i
);
  import orlk_pkg::*;

  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned TW = (LengthW + CW > OffsetW) ? LengthW + CW : OffsetW + 1;

  state_e             state_q, state_d;
  item_t              item_q, item_d;
  result_t            res_q, res_d;
  logic [IW-1:0]      ws_q, ws_d, rs_q, rs_d;
  logic               full_q, full_d;
  logic [TW-1:0]      total_q, total_d;
  logic [TW-1:0]      acc_q, acc_d;
  logic [CW-1:0]      iss_q, iss_d, chk_q, chk_d, lst_q, lst_d;
  logic               rvld_q, rvld_d;
  logic [CW-1:0]      cnt;
  logic [IW-1:0]      ws_nxt, rs_nxt, iss_slot, chk_slot;
  logic               last_chk;
  logic [TW:0]        operand, sum, diff;
  logic [SlotW+IW-1:0] slot_ext;

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                            input logic [IW-1:0] idx);
    logic [IW:0] s;
    s = {1'b0, base} + {1'b0, idx};
    if (s >= (IW+1)'(RING_DEPTH)) begin
      s = s - (IW+1)'(RING_DEPTH);
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] inc(input logic [IW-1:0] p);
    return (p == IW'(RING_DEPTH - 1)) ? '0 : IW'(p + 1'b1);
  endfunction

  assign ws_nxt   = inc(ws_q);
  assign rs_nxt   = inc(rs_q);
  assign iss_slot = slot_of(rs_q, iss_q[IW-1:0]);
  assign chk_slot = slot_of(rs_q, chk_q[IW-1:0]);
  assign last_chk = (chk_q == lst_q);
  assign slot_ext = {{SlotW{1'b0}}, chk_slot};

  always_comb begin
    if (full_q) begin
      cnt = CW'(RING_DEPTH);
    end else if (ws_q >= rs_q) begin
      cnt = CW'(ws_q - rs_q);
    end else begin
      cnt = CW'((IW+1)'(RING_DEPTH) + {1'b0, ws_q} - {1'b0, rs_q});
    end
  end

  // shared add/compare unit
  always_comb begin
    if (item_q.operation == OP_POS && last_chk) begin
      operand = (TW+1)'(item_q.offset_in_entry);
    end else begin
      operand = (TW+1)'(rd_length_i);
    end
    sum  = {1'b0, acc_q} + operand;
    diff = (TW+1)'(item_q.stream_offset) - {1'b0, acc_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ws_q    <= '0;
      rs_q    <= '0;
      full_q  <= 1'b0;
      total_q <= '0;
      iss_q   <= '0;
      chk_q   <= '0;
      lst_q   <= '0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ws_q    <= ws_d;
      rs_q    <= rs_d;
      full_q  <= full_d;
      total_q <= total_d;
      iss_q   <= iss_d;
      chk_q   <= chk_d;
      lst_q   <= lst_d;
      rvld_q  <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    acc_q  <= acc_d;
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    res_d       = res_q;
    ws_d        = ws_q;
    rs_d        = rs_q;
    full_d      = full_q;
    total_d     = total_q;
    acc_d       = acc_q;
    iss_d       = iss_q;
    chk_d       = chk_q;
    lst_d       = lst_q;
    rvld_d      = 1'b0;
    ready_o     = 1'b0;
    res_valid_o = 1'b0;
    wr_en_o     = 1'b0;
    wr_addr_o   = ws_q;
    wr_handle_o = item_q.new_handle;
    wr_length_o = item_q.new_length;
    rd_addr_o   = rs_q;

    case (state_q)
      ST_IDLE: begin
        ready_o = 1'b1;
        if (start_i) begin
          item_d = item_i;
          res_d  = '0;
          acc_d  = '0;
          iss_d  = '0;
          chk_d  = '0;
          case (item_i.operation)
            OP_APPEND: state_d = ST_APPEND;
            OP_FIND: begin
              if (cnt == '0) begin
                state_d = ST_DONE;
              end else begin
                lst_d   = CW'(cnt - 1'b1);
                state_d = ST_WALK;
              end
            end
            OP_POS: begin
              if (item_i.entry_position >= PosW'(cnt)) begin
                res_d.position_error = 1'b1;
                state_d = ST_DONE;
              end else begin
                lst_d   = CW'(item_i.entry_position);
                state_d = ST_WALK;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      ST_APPEND: begin
        wr_en_o = 1'b1;
        ws_d    = ws_nxt;
        if (full_q) begin
          if (rd_handle_i != '0) begin
            res_d.evicted_valid  = 1'b1;
            res_d.evicted_handle = rd_handle_i;
          end
          rs_d    = rs_nxt;
          total_d = TW'(total_q - TW'(rd_length_i) + TW'(item_q.new_length));
          full_d  = 1'b1;
        end else begin
          total_d = TW'(total_q + TW'(item_q.new_length));
          full_d  = (ws_nxt == rs_q);
        end
        state_d = ST_DONE;
      end

      ST_WALK: begin
        rd_addr_o = iss_slot;
        if (iss_q <= lst_q) begin
          rvld_d = 1'b1;
          iss_d  = CW'(iss_q + 1'b1);
        end
        if (rvld_q) begin
          chk_d = CW'(chk_q + 1'b1);
          acc_d = sum[TW-1:0];
          if (item_q.operation == OP_FIND) begin
            if ((TW+1)'(item_q.stream_offset) < sum) begin
              res_d.found         = 1'b1;
              res_d.slot_index    = slot_ext[SlotW-1:0];
              res_d.slot_handle   = rd_handle_i;
              res_d.byte_in_entry = diff[LengthW-1:0];
              state_d = ST_DONE;
            end else if (last_chk) begin
              state_d = ST_DONE;
            end
          end else if (last_chk) begin
            if (item_q.offset_in_entry <= rd_length_i) begin
              res_d.absolute_offset = (sum > (TW+1)'(OffsetMax)) ? OffsetMax
                                                                 : sum[OffsetW-1:0];
            end else begin
              res_d.position_error = 1'b1;
            end
            state_d = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ack_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_o              = res_q;
    res_o.total_length = (total_q > TW'(OffsetMax)) ? OffsetMax : total_q[OffsetW-1:0];
  end

endmodule

`default_nettype wire

// File: rtl/core/overwriting_ring_with_offset_lookup_top.sv
// ----------------------------------------------------------------------------
// overwriting_ring_with_offset_lookup_top
// Ring of handle/length entries with append-overwrite and offset lookup.
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  s_axis    in   tvalid/tready/tdata   operation, handles, offsets, position
//  m_axis    out  tvalid/tready/tdata   lookup results, eviction, total length
//
// An append writes its entry and loads the result register in ST_APPEND.
// A find or position lookup walks the stored lengths through one adder/compare,
// one entry per cycle after a registered memory read.
// One item at a time; s_axis_tready_o is low from accept until the result
// is loaded into the output register. Reset empties the ring at once.
// ----------------------------------------------------------------------------
`default_nettype none

module overwriting_ring_with_offset_lookup_top #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // operation, new_handle, new_length, stream_offset, entry_position,
  // offset_in_entry
  input  wire logic [orlk_pkg::InDataW-1:0]     s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // found, slot_index, slot_handle, byte_in_entry, absolute_offset,
  // position_error, evicted_valid, evicted_handle, total_length
  output logic      [orlk_pkg::OutDataW-1:0]    m_axis_tdata_o
);
  import orlk_pkg::*;

  localparam int unsigned IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  item_t               item;
  result_t             res;
  logic                ready, start, res_valid, res_ack;
  logic                wr_en;
  logic [IW-1:0]       wr_addr, rd_addr;
  logic [HandleW-1:0]  wr_handle, rd_handle;
  logic [LengthW-1:0]  wr_length, rd_length;
  logic                m_tvalid_q;
  logic [OutDataW-1:0] m_tdata_q;

  assign item            = s_axis_tdata_i[$bits(item_t)-1:0];
  assign s_axis_tready_o = ready;
  assign start           = s_axis_tvalid_i && ready;
  assign res_ack         = !m_tvalid_q || m_axis_tready_i;

  orlk_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .IW         (IW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (item),
    .ready_o     (ready),
    .res_valid_o (res_valid),
    .res_ack_i   (res_ack),
    .res_o       (res),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_handle_o (wr_handle),
    .wr_length_o (wr_length),
    .rd_addr_o   (rd_addr),
    .rd_handle_i (rd_handle),
    .rd_length_i (rd_length)
  );

  orlk_store #(
    .RING_DEPTH (RING_DEPTH),
    .IW         (IW)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_handle_i (wr_handle),
    .wr_length_i (wr_length),
    .rd_addr_i   (rd_addr),
    .rd_handle_o (rd_handle),
    .rd_length_o (rd_length)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (res_valid && res_ack) begin
      m_tvalid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ack) begin
      m_tdata_q <= OutDataW'(res);
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the overwriting ring with offset lookup. Items are sent on
// the input stream while a scoreboard model of the ring computes the
// expected result of each one. Every result on the output stream is checked
// against the oldest pending expectation. Directed items cover the empty
// ring, fill-up, wrap with and without eviction and lookup edges. Random
// items follow, mostly lookups aimed inside the stored stream, first with random
// idle and stall bursts on both sides, then without.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import orlk_pkg::*;

  localparam int unsigned RingDepth = 16;
  localparam int unsigned ItemW     = $bits(item_t);
  localparam int unsigned ResultW   = $bits(result_t);

  logic                clk_i;
  logic                rst_n;
  logic                s_valid;
  logic                s_ready;
  logic [InDataW-1:0]  s_data;
  logic                m_valid;
  logic                m_ready;
  logic [OutDataW-1:0] m_data;

  logic [HandleW-1:0] ring_handle [RingDepth];
  logic [LengthW-1:0] ring_len    [RingDepth];
  int unsigned        wr_slot;
  int unsigned        rd_slot;
  bit                 ring_full_q;

  result_t     pending_results [$];
  bit          idle_en;
  bit          stall_en;
  int unsigned mismatch_cnt;
  int unsigned n_append, n_evict, n_find, n_hit, n_pos, n_pos_err, n_none;

  overwriting_ring_with_offset_lookup_top #(
    .RING_DEPTH(RingDepth)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [OffsetW-1:0] sat20(input int unsigned v);
    return (v > OffsetMax) ? OffsetMax : v[OffsetW-1:0];
  endfunction

  function automatic int unsigned stored_entries();
    if (ring_full_q) return RingDepth;
    return (wr_slot + RingDepth - rd_slot) % RingDepth;
  endfunction

  function automatic int unsigned stream_total();
    int unsigned s;
    s = 0;
    for (int unsigned i = 0; i < stored_entries(); i++)
      s += ring_len[(rd_slot + i) % RingDepth];
    return s;
  endfunction

  function automatic result_t ring_apply(input item_t it);
    result_t     r;
    int unsigned cnt, acc, slot;
    bit          hit;
    r   = '0;
    cnt = stored_entries();
    acc = 0;
    hit = 1'b0;
    case (it.operation)
      OP_APPEND: begin
        n_append++;
        if (ring_full_q) begin
          if (ring_handle[rd_slot] != '0) begin
            r.evicted_valid  = 1'b1;
            r.evicted_handle = ring_handle[rd_slot];
            n_evict++;
          end
          rd_slot = (rd_slot + 1) % RingDepth;
        end
        ring_handle[wr_slot] = it.new_handle;
        ring_len[wr_slot]    = it.new_length;
        wr_slot = (wr_slot + 1) % RingDepth;
        if (wr_slot == rd_slot) ring_full_q = 1'b1;
      end
      OP_FIND: begin
        n_find++;
        for (int unsigned i = 0; i < cnt; i++) begin
          slot = (rd_slot + i) % RingDepth;
          if (!hit) begin
            if (it.stream_offset < acc + ring_len[slot]) begin
              hit             = 1'b1;
              r.found         = 1'b1;
              r.slot_index    = SlotW'(slot);
              r.slot_handle   = ring_handle[slot];
              r.byte_in_entry = LengthW'(it.stream_offset - acc);
              n_hit++;
            end else begin
              acc += ring_len[slot];
            end
          end
        end
      end
      OP_POS: begin
        n_pos++;
        if (it.entry_position >= cnt) begin
          r.position_error = 1'b1;
        end else begin
          for (int unsigned i = 0; i < it.entry_position; i++)
            acc += ring_len[(rd_slot + i) % RingDepth];
          slot = (rd_slot + it.entry_position) % RingDepth;
          if (it.offset_in_entry <= ring_len[slot]) begin
            r.absolute_offset = sat20(acc + it.offset_in_entry);
          end else begin
            r.position_error = 1'b1;
          end
        end
        if (r.position_error) n_pos_err++;
      end
      default: begin
        n_none++;
      end
    endcase
    r.total_length = sat20(stream_total());
    return r;
  endfunction

  function automatic item_t rand_item(input op_e op);
    item_t it;
    it.operation       = op;
    it.new_handle      = HandleW'($urandom);
    it.new_length      = LengthW'($urandom);
    it.stream_offset   = OffsetW'($urandom);
    it.entry_position  = PosW'($urandom);
    it.offset_in_entry = HandleW'($urandom);
    return it;
  endfunction

  task automatic send_item(input item_t it);
    if (idle_en && $urandom_range(0, 2) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {{(InDataW - ItemW){1'b0}}, it};
    do @(posedge clk_i); while (!s_ready);
    pending_results.push_back(ring_apply(it));
    @(negedge clk_i);
  endtask

  task automatic report_mismatch(input result_t exp_r, input result_t got_r);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("[%0t] mismatch: exp found=%0d slot=%0d hnd=%h bie=%h abs=%h perr=%0d",
               $time, exp_r.found, exp_r.slot_index, exp_r.slot_handle,
               exp_r.byte_in_entry, exp_r.absolute_offset, exp_r.position_error);
      $display("    exp ev=%0d evh=%h total=%h", exp_r.evicted_valid,
               exp_r.evicted_handle, exp_r.total_length);
      $display("    got found=%0d slot=%0d hnd=%h bie=%h abs=%h perr=%0d",
               got_r.found, got_r.slot_index, got_r.slot_handle,
               got_r.byte_in_entry, got_r.absolute_offset, got_r.position_error);
      $display("    got ev=%0d evh=%h total=%h", got_r.evicted_valid,
               got_r.evicted_handle, got_r.total_length);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t got_r;
    result_t exp_r;
    if (rst_n && m_valid && m_ready) begin
      got_r = result_t'(m_data[ResultW-1:0]);
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("[%0t] result with no item pending", $time);
      end else begin
        exp_r = pending_results.pop_front();
        if (got_r.found           !== exp_r.found           ||
            got_r.slot_index      !== exp_r.slot_index      ||
            got_r.slot_handle     !== exp_r.slot_handle     ||
            got_r.byte_in_entry   !== exp_r.byte_in_entry   ||
            got_r.absolute_offset !== exp_r.absolute_offset ||
            got_r.position_error  !== exp_r.position_error  ||
            got_r.evicted_valid   !== exp_r.evicted_valid   ||
            got_r.evicted_handle  !== exp_r.evicted_handle  ||
            got_r.total_length    !== exp_r.total_length)
          report_mismatch(exp_r, got_r);
      end
    end
  end

  initial begin : ready_stall
    m_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (stall_en && $urandom_range(0, 3) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
      end
      m_ready <= 1'b1;
      @(negedge clk_i);
    end
  end

  task automatic test_empty_ring();
    item_t it;
    it = rand_item(OP_FIND);
    it.stream_offset = '0;
    send_item(it);
    it = rand_item(OP_POS);
    it.entry_position  = '0;
    it.offset_in_entry = '0;
    send_item(it);
    send_item(rand_item(OP_NONE));
  endtask

  task automatic test_fill_and_wrap();
    item_t it;
    for (int i = 0; i < RingDepth; i++) begin
      it = rand_item(OP_APPEND);
      if (i == 0) it.new_handle = '1;
      if (i == 1) it.new_handle = '0;
      it.new_length = (i == 2) ? '0 : (i == 3) ? 16'h0010 : '1;
      send_item(it);
    end
    // land on the start of the entry that follows the zero-length one
    it = rand_item(OP_FIND);
    it.stream_offset = 20'(2 * 32'h0000_FFFF);
    send_item(it);
    it = rand_item(OP_FIND);
    it.stream_offset = '1;
    send_item(it);
    it = rand_item(OP_POS);
    it.entry_position  = 8'd3;
    it.offset_in_entry = 16'h0010;
    send_item(it);
    it.offset_in_entry = 16'h0011;
    send_item(it);
    it.entry_position  = PosW'(RingDepth);
    it.offset_in_entry = '0;
    send_item(it);
    it.entry_position  = '1;
    it.offset_in_entry = '1;
    send_item(it);
    // overwrite a non-zero handle, then a zero handle
    send_item(rand_item(OP_APPEND));
    send_item(rand_item(OP_APPEND));
  endtask

  task automatic test_random_ops(input int unsigned n_items);
    item_t       it;
    int unsigned pick, cnt, total, slot;
    for (int unsigned k = 0; k < n_items; k++) begin
      pick  = $urandom_range(0, 99);
      cnt   = stored_entries();
      total = stream_total();
      if (pick < 30) begin
        it = rand_item(OP_APPEND);
        if ($urandom_range(0, 3) == 0) it.new_length = LengthW'($urandom_range(0, 15));
      end else if (pick < 62) begin
        it = rand_item(OP_FIND);
        if (total > 0 && $urandom_range(0, 7) != 0)
          it.stream_offset = OffsetW'($urandom_range(0, total));
      end else if (pick < 95) begin
        it = rand_item(OP_POS);
        if (cnt > 0 && $urandom_range(0, 7) != 0) begin
          it.entry_position = PosW'($urandom_range(0, cnt - 1));
          slot = (rd_slot + it.entry_position) % RingDepth;
          case ($urandom_range(0, 5))
            0: it.offset_in_entry = ring_len[slot];
            1: it.offset_in_entry = ring_len[slot] + 16'd1;
            2: ;
            default: it.offset_in_entry = LengthW'($urandom_range(0, ring_len[slot]));
          endcase
        end
      end else begin
        it = rand_item(OP_NONE);
      end
      send_item(it);
    end
  endtask

  initial begin : main_seq
    rst_n        = 1'b0;
    s_valid      = 1'b0;
    s_data       = '0;
    idle_en      = 1'b1;
    stall_en     = 1'b1;
    mismatch_cnt = 0;
    wr_slot      = 0;
    rd_slot      = 0;
    ring_full_q  = 1'b0;
    for (int i = 0; i < RingDepth; i++) begin
      ring_handle[i] = '0;
      ring_len[i]    = '0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    test_empty_ring();
    test_fill_and_wrap();
    test_random_ops(370);
    idle_en  = 1'b0;
    stall_en = 1'b0;
    test_random_ops(60);
    s_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (RingDepth + 8) @(posedge clk_i);

    $display("Covered %0d appends (%0d evictions), %0d finds (%0d hits),",
             n_append, n_evict, n_find, n_hit);
    $display("%0d position lookups (%0d errors), %0d no-ops; %0d mismatches",
             n_pos, n_pos_err, n_none, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
